// ----- sv/fla_pkg.sv -----
`default_nettype none

package fla_pkg;

    localparam int PAGE_COUNT     = 8192;
    localparam int RESERVED_PAGES = 60;
    localparam int HEADER_BYTES   = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_OBJECT_BYTES   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOTS_PER_PAGE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_LIMIT     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_OFFSET    = 2'd3;

    localparam logic [9:0]  OBJECT_BYTES_RESET   = 10'd26;
    localparam logic [7:0]  SLOTS_PER_PAGE_RESET = 8'd16;
    localparam logic [13:0] PAGE_LIMIT_RESET     = 14'(PAGE_COUNT - RESERVED_PAGES);
    localparam logic [12:0] PAGE_OFFSET_RESET    = 13'd0;

    localparam logic [1:0] CMD_ERASE  = 2'd0;
    localparam logic [1:0] CMD_OBJECT = 2'd1;
    localparam logic [1:0] CMD_HEADER = 2'd2;

    localparam logic [15:0] SEQ_FIRST = 16'h0101;
    localparam logic [15:0] SEQ_SKIP  = 16'hFFFF;

    typedef struct packed {
        logic [9:0]  object_bytes;
        logic [7:0]  slots_per_page;
        logic [13:0] page_limit;
        logic [12:0] page_offset;
    } cfg_t;

    typedef struct packed {
        logic        erase;
        logic [12:0] page;
        logic [13:0] header_page;
        logic [10:0] slot_base;
        logic [9:0]  length;
        logic [15:0] sequence_value;
        logic [7:0]  session;
    } job_t;

endpackage

`default_nettype wire

// ----- sv/fla_in_if.sv -----
`default_nettype none

interface fla_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] session_tag;
    logic [9:0] object_length;

    modport source (output valid, output session_tag, output object_length, input ready);
    modport sink (input valid, input session_tag, input object_length, output ready);
endinterface

`default_nettype wire

// ----- sv/fla_out_if.sv -----
`default_nettype none

interface fla_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command_kind;
    logic [13:0] page_index;
    logic [10:0] byte_offset;
    logic [9:0]  byte_count;
    logic [15:0] sequence_value;
    logic [7:0]  header_session;
    logic        last_command;

    modport source (
        output valid, output command_kind, output page_index, output byte_offset,
        output byte_count, output sequence_value, output header_session,
        output last_command, input ready
    );
    modport sink (
        input valid, input command_kind, input page_index, input byte_offset,
        input byte_count, input sequence_value, input header_session,
        input last_command, output ready
    );
endinterface

`default_nettype wire

// ----- sv/fla_front.sv -----
`default_nettype none

module fla_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire fla_pkg::cfg_t cfg,
    fla_in_if.sink           request,
    output fla_pkg::job_t    job,
    output logic             job_valid,
    input  wire logic        job_ready
);

    logic [12:0] head_page_reg;
    logic [12:0] head_page_next;
    logic [7:0]  head_slot_reg;
    logic [7:0]  head_slot_next;
    logic [15:0] seq_reg;
    logic [15:0] seq_next;
    logic [7:0]  prev_session_reg;
    logic        first_reg;

    logic        accept;
    logic        skip;
    logic [12:0] eff_page;
    logic [7:0]  eff_slot;
    logic [10:0] stride;
    logic [10:0] product;
    logic [10:0] slot_base;
    logic [8:0]  inc_slot;
    logic        advance;
    logic [15:0] seq_inc;

    function automatic logic [12:0] next_page(input logic [12:0] page,
                                              input logic [13:0] limit);
        logic [13:0] p;
        begin
            p = {1'b0, page} + 14'd1;
            if (p >= limit)
            begin
                p = 14'd0;
            end
            return p[12:0];
        end
    endfunction

    assign accept = request.valid && job_ready;
    assign request.ready = job_ready;
    assign job_valid = request.valid;

    assign skip = !first_reg && (head_slot_reg != 8'd0)
                  && (request.session_tag != prev_session_reg);
    assign eff_page = skip ? next_page(head_page_reg, cfg.page_limit) : head_page_reg;
    assign eff_slot = skip ? 8'd0 : head_slot_reg;

    assign stride = 11'(fla_pkg::HEADER_BYTES) + {1'b0, cfg.object_bytes};
    assign product = 11'(stride * head_slot_reg);
    assign slot_base = skip ? 11'd0 : product;

    assign inc_slot = {1'b0, eff_slot} + 9'd1;
    assign advance = inc_slot >= {1'b0, cfg.slots_per_page};
    assign head_slot_next = advance ? 8'd0 : inc_slot[7:0];
    assign head_page_next = advance ? next_page(eff_page, cfg.page_limit) : eff_page;

    assign seq_inc = seq_reg + 16'd1;
    assign seq_next = ((seq_inc < fla_pkg::SEQ_FIRST) || (seq_inc == fla_pkg::SEQ_SKIP))
                      ? fla_pkg::SEQ_FIRST : seq_inc;

    always_comb
    begin
        job.erase = eff_slot == 8'd0;
        job.page = eff_page;
        job.header_page = {1'b0, cfg.page_offset} + {1'b0, eff_page};
        job.slot_base = slot_base;
        job.length = request.object_length;
        job.sequence_value = seq_next;
        job.session = request.session_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_page_reg <= '0;
            head_slot_reg <= '0;
            seq_reg <= '0;
            prev_session_reg <= '0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            head_page_reg <= head_page_next;
            head_slot_reg <= head_slot_next;
            seq_reg <= seq_next;
            prev_session_reg <= request.session_tag;
            first_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/fla_queue.sv -----
`default_nettype none

module fla_queue #(
    parameter int QUEUE_DEPTH = fla_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fla_pkg::job_t push_job,
    input  wire logic          push_valid,
    output logic               push_ready,
    output fla_pkg::job_t      pop_job,
    output logic               pop_valid,
    input  wire logic          pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    fla_pkg::job_t    entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid = count_reg != '0;
    assign pop_job = entries[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/fla_back.sv -----
`default_nettype none

module fla_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fla_pkg::job_t job,
    input  wire logic          job_valid,
    output logic               job_ready,
    fla_out_if.source          command
);

    fla_pkg::job_t cur_reg;
    logic          cur_valid_reg;
    logic [1:0]    step_reg;
    logic          load;
    logic          emit;
    logic          finish;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [13:0] page_reg;
    logic [10:0] offset_reg;
    logic [9:0]  count_reg;
    logic [15:0] seq_reg;
    logic [7:0]  session_reg;
    logic        last_reg;

    logic [1:0]  kind_next;
    logic [13:0] page_next;
    logic [10:0] offset_next;
    logic [9:0]  count_next;
    logic [15:0] seq_next;
    logic [7:0]  session_next;
    logic        last_next;

    assign load = !out_valid_reg || command.ready;
    assign emit = load && cur_valid_reg;
    assign finish = emit && (step_reg == fla_pkg::CMD_HEADER);
    assign job_ready = !cur_valid_reg || finish;

    always_comb
    begin
        kind_next = step_reg;
        page_next = {1'b0, cur_reg.page};
        offset_next = 11'd0;
        count_next = 10'd0;
        seq_next = 16'd0;
        session_next = 8'd0;
        last_next = 1'b0;
        unique case (step_reg)
            fla_pkg::CMD_ERASE:
            begin
            end
            fla_pkg::CMD_OBJECT:
            begin
                offset_next = cur_reg.slot_base + 11'(fla_pkg::HEADER_BYTES);
                count_next = cur_reg.length;
            end
            fla_pkg::CMD_HEADER:
            begin
                page_next = cur_reg.header_page;
                offset_next = cur_reg.slot_base;
                count_next = 10'(fla_pkg::HEADER_BYTES);
                seq_next = cur_reg.sequence_value;
                session_next = cur_reg.session;
                last_next = 1'b1;
            end
            default:
            begin
                kind_next = fla_pkg::CMD_HEADER;
                last_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg <= fla_pkg::CMD_ERASE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
            begin
                cur_valid_reg <= job_valid;
                step_reg <= job.erase ? fla_pkg::CMD_ERASE : fla_pkg::CMD_OBJECT;
            end
            else if (emit)
            begin
                step_reg <= (step_reg == fla_pkg::CMD_ERASE) ? fla_pkg::CMD_OBJECT
                                                             : fla_pkg::CMD_HEADER;
            end
            if (load)
            begin
                out_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
        begin
            cur_reg <= job;
        end
        if (emit)
        begin
            kind_reg <= kind_next;
            page_reg <= page_next;
            offset_reg <= offset_next;
            count_reg <= count_next;
            seq_reg <= seq_next;
            session_reg <= session_next;
            last_reg <= last_next;
        end
    end

    assign command.valid = out_valid_reg;
    assign command.command_kind = kind_reg;
    assign command.page_index = page_reg;
    assign command.byte_offset = offset_reg;
    assign command.byte_count = count_reg;
    assign command.sequence_value = seq_reg;
    assign command.header_session = session_reg;
    assign command.last_command = last_reg;

endmodule

`default_nettype wire

// ----- sv/flash_log_append_sequencer.sv -----
// Channel   Direction  Payload
// request   in         session_tag, object_length
// command   out        command_kind, page_index, byte_offset, byte_count,
//                      sequence_value, header_session, last_command
//
// An append issues two commands on the command channel without an erase and
// three with one; the command emitter issues one command per cycle when not stalled.
// A request is taken whenever the job queue has room.
// The first command of an append passes the job queue, the current-job register and the output register.
// Reset clears the write head and restores the register defaults.
// Each channel stalls on its own through the job queue and the output register.
`default_nettype none

module flash_log_append_sequencer #(
    parameter int QUEUE_DEPTH = fla_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    fla_in_if.sink                                 request,
    fla_out_if.source                              command,
    input  wire logic                              write_enable,
    input  wire logic [fla_pkg::CFG_INDEX_W-1:0]   write_index,
    input  wire logic [fla_pkg::CFG_DATA_W-1:0]    write_data
);

    fla_pkg::cfg_t cfg_reg;
    fla_pkg::job_t front_job;
    fla_pkg::job_t back_job;
    logic          front_valid;
    logic          front_ready;
    logic          back_valid;
    logic          back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.object_bytes <= fla_pkg::OBJECT_BYTES_RESET;
            cfg_reg.slots_per_page <= fla_pkg::SLOTS_PER_PAGE_RESET;
            cfg_reg.page_limit <= fla_pkg::PAGE_LIMIT_RESET;
            cfg_reg.page_offset <= fla_pkg::PAGE_OFFSET_RESET;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                fla_pkg::REG_OBJECT_BYTES:   cfg_reg.object_bytes <= write_data[9:0];
                fla_pkg::REG_SLOTS_PER_PAGE: cfg_reg.slots_per_page <= write_data[7:0];
                fla_pkg::REG_PAGE_LIMIT:     cfg_reg.page_limit <= write_data[13:0];
                fla_pkg::REG_PAGE_OFFSET:    cfg_reg.page_offset <= write_data[12:0];
            endcase
        end
    end

    fla_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .request   (request),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    fla_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_job    (back_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    fla_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .command   (command)
    );

    a_last_on_header: assert property (@(posedge clk) disable iff (!rst_n)
        command.valid |-> (command.last_command == (command.command_kind == fla_pkg::CMD_HEADER)))
        else $error("last_command does not mark the header program");

    a_erase_then_object: assert property (@(posedge clk) disable iff (!rst_n)
        (command.valid && command.ready && command.command_kind == fla_pkg::CMD_ERASE)
        |=> (command.valid && command.command_kind == fla_pkg::CMD_OBJECT))
        else $error("erase transfer not followed by an object program");

    a_object_then_header: assert property (@(posedge clk) disable iff (!rst_n)
        (command.valid && command.ready && command.command_kind == fla_pkg::CMD_OBJECT)
        |=> (command.valid && command.command_kind == fla_pkg::CMD_HEADER))
        else $error("object transfer not followed by a header program");

endmodule

`default_nettype wire
